>>> sv/cmmc_pkg.sv
// Shared types and constants for the multicycle mini MIPS core.
`default_nettype none
package cmmc_pkg;

    localparam int MEM_DEPTH_DEF = 256;
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_W     = 3;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_START = 2'd1,
        REQ_STEP  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        PH_FETCH  = 3'd0,
        PH_DECODE = 3'd1,
        PH_ALU    = 3'd2,
        PH_WB     = 3'd3,
        PH_LWB    = 3'd4
    } t_phase;

    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_ADDI  = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_AND = 3'd2;
    localparam logic [2:0] FN_OR  = 3'd3;

endpackage
`default_nettype wire

>>> sv/multicycle_mini_mips_core_unit.sv
// Top level of the multicycle mini MIPS core: request handling and datapath.
//
//  channel | direction | handshake          | payload
//  request | in        | i_valid / o_stall  | i_req_type, i_load_addr, i_load_word
//  result  | out       | o_valid / i_stall  | o_pc_value .. o_micro_steps_done
//  config  | in        | i_cfg_we           | i_cfg_data (program length)
//
// A request first issues the synchronous memory and register file reads, then
// uses the read data, writes back and fills the output register.
// The next request is taken once the previous one has moved to the output register.
// Reset is synchronous, active low; the core comes out of reset halted.
// A stalled result holds the output register and stalls the request side.
`default_nettype none
module multicycle_mini_mips_core_unit #(
    parameter int MEM_DEPTH = cmmc_pkg::MEM_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_load_addr,
    input  wire logic [15:0] i_load_word,
    input  wire logic        i_cfg_we,
    input  wire logic [8:0]  i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [8:0]       o_pc_value,
    output logic [2:0]       o_phase,
    output logic             o_halted,
    output logic             o_reg_write_en,
    output logic [2:0]       o_reg_write_index,
    output logic signed [31:0] o_reg_write_value,
    output logic             o_mem_write_en,
    output logic [7:0]       o_mem_write_addr,
    output logic [15:0]      o_mem_write_data,
    output logic [31:0]      o_micro_steps_done
);
    import cmmc_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    // Architectural state
    logic [8:0]  r_plen, r_pc;
    logic [15:0] r_ir;
    logic [31:0] r_opa, r_opb, r_alu, r_mdr, r_cnt;
    t_phase      r_phase;
    logic        r_halt;
    // Request in flight
    logic        r_busy;
    t_req        r_req;

    logic [8:0]  n_pc;
    logic [15:0] n_ir;
    logic [31:0] n_opa, n_opb, n_alu, n_mdr, n_cnt;
    t_phase      n_phase;
    logic        n_halt;
    logic        n_rwe, n_mwe;
    logic [2:0]  n_ridx;
    logic [31:0] n_rval;
    logic [7:0]  n_maddr;
    logic [15:0] n_mdata;

    logic        accept, done, load_ok;
    logic [3:0]  op;
    logic [15:0] mem_rdata;
    logic [31:0] rf_a, rf_b;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_wdata;

    assign o_stall = r_busy | (o_valid & i_stall);
    assign accept  = i_valid & ~o_stall;
    assign done    = r_busy & ~(o_valid & i_stall);
    assign op      = r_ir[15:12];
    assign load_ok = ({1'b0, i_load_addr} < 9'(MEM_DEPTH));

    // Memory ports: loads write on accept, stores write when the step completes
    assign mem_we    = (accept && t_req'(i_req_type) == REQ_LOAD && load_ok) || (done && n_mwe);
    assign mem_waddr = done ? r_alu[AW-1:0] : i_load_addr[AW-1:0];
    assign mem_wdata = done ? r_opb[15:0] : i_load_word;
    assign mem_raddr = (r_phase == PH_FETCH) ? r_pc[AW-1:0] : r_alu[AW-1:0];

    cmmc_wmem #(.MEM_DEPTH(MEM_DEPTH), .AW(AW)) u_wmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    cmmc_rf u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (done & n_rwe),
        .i_waddr   (n_ridx),
        .i_wdata   (n_rval),
        .i_raddr_a (r_ir[11:9]),
        .i_raddr_b (r_ir[8:6]),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b)
    );

    // Execute the request with the read data now available
    always_comb begin
        n_pc = r_pc;   n_ir = r_ir;   n_opa = r_opa; n_opb = r_opb;
        n_alu = r_alu; n_mdr = r_mdr; n_cnt = r_cnt;
        n_phase = r_phase; n_halt = r_halt;
        n_rwe = 1'b0; n_ridx = 3'd0; n_rval = 32'd0;
        n_mwe = 1'b0; n_maddr = 8'd0; n_mdata = 16'd0;
        case (r_req)
            REQ_START: begin
                if (r_plen != 9'd0) n_halt = 1'b0;
            end
            REQ_STEP: begin
                if (!r_halt) begin
                    case (r_phase)
                        PH_FETCH: begin
                            n_ir    = (32'(r_pc) < 32'(MEM_DEPTH)) ? mem_rdata : 16'd0;
                            n_pc    = r_pc + 9'd1;
                            n_phase = PH_DECODE;
                        end
                        PH_DECODE: begin
                            n_opa   = rf_a;
                            n_opb   = rf_b;
                            n_phase = PH_ALU;
                        end
                        PH_ALU: begin
                            if (op == OP_RTYPE) begin
                                case (r_ir[2:0])
                                    FN_ADD:  n_alu = r_opa + r_opb;
                                    FN_SUB:  n_alu = r_opa - r_opb;
                                    FN_AND:  n_alu = r_opa & r_opb;
                                    FN_OR:   n_alu = r_opa | r_opb;
                                    default: n_alu = 32'd0;
                                endcase
                            end else if (op == OP_ADDI || op == OP_LW || op == OP_SW) begin
                                n_alu = r_opa + {26'd0, r_ir[5:0]};
                            end
                            n_phase = PH_WB;
                        end
                        PH_WB: begin
                            n_phase = PH_FETCH;
                            if (op == OP_RTYPE || op == OP_ADDI) begin
                                n_rwe  = 1'b1;
                                n_ridx = (op == OP_RTYPE) ? r_ir[5:3] : r_ir[8:6];
                                n_rval = r_alu;
                            end else if (op == OP_LW) begin
                                if (r_alu < 32'(MEM_DEPTH)) begin
                                    n_mdr = {{16{mem_rdata[15]}}, mem_rdata};
                                end
                                n_phase = PH_LWB;
                            end else if (op == OP_SW) begin
                                if (r_alu < 32'(MEM_DEPTH)) begin
                                    n_mwe   = 1'b1;
                                    n_maddr = r_alu[7:0];
                                    n_mdata = r_opb[15:0];
                                end
                            end
                        end
                        PH_LWB: begin
                            if (op == OP_LW) begin
                                n_rwe  = 1'b1;
                                n_ridx = r_ir[8:6];
                                n_rval = r_mdr;
                            end
                            n_phase = PH_FETCH;
                        end
                        default: n_phase = PH_FETCH;
                    endcase
                    n_cnt = r_cnt + 32'd1;
                    if (n_phase == PH_FETCH && n_pc >= r_plen) n_halt = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_req   <= REQ_LOAD;
            r_plen  <= 9'd0;
            r_pc    <= 9'd0;
            r_ir    <= 16'd0;
            r_opa   <= 32'd0;
            r_opb   <= 32'd0;
            r_alu   <= 32'd0;
            r_mdr   <= 32'd0;
            r_cnt   <= 32'd0;
            r_phase <= PH_FETCH;
            r_halt  <= 1'b1;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_plen <= i_cfg_data;
            if (accept) begin
                r_busy <= 1'b1;
                r_req  <= t_req'(i_req_type);
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_pc <= n_pc;   r_ir <= n_ir;   r_opa <= n_opa; r_opb <= n_opb;
                r_alu <= n_alu; r_mdr <= n_mdr; r_cnt <= n_cnt;
                r_phase <= n_phase; r_halt <= n_halt;
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (done) begin
            o_pc_value         <= n_pc;
            o_phase            <= n_phase;
            o_halted           <= n_halt;
            o_reg_write_en     <= n_rwe;
            o_reg_write_index  <= n_ridx;
            o_reg_write_value  <= n_rval;
            o_mem_write_en     <= n_mwe;
            o_mem_write_addr   <= n_maddr;
            o_mem_write_data   <= n_mdata;
            o_micro_steps_done <= n_cnt;
        end
    end
endmodule
`default_nettype wire

>>> sv/cmmc_wmem.sv
// Unified word memory: one write port, one registered read port, valid bits.
`default_nettype none
module cmmc_wmem #(
    parameter int MEM_DEPTH = cmmc_pkg::MEM_DEPTH_DEF,
    parameter int AW        = $clog2(MEM_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [15:0]        o_rdata
);
    import cmmc_pkg::*;

    logic [15:0]          r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    logic [15:0]          r_rdata;
    logic                 r_rvld;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits: entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        r_rvld  <= r_vld[i_raddr];
    end

    assign o_rdata = r_rvld ? r_rdata : 16'd0;
endmodule
`default_nettype wire

>>> sv/cmmc_rf.sv
// Register file: eight 32-bit registers, two registered reads, one write.
`default_nettype none
module cmmc_rf (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [cmmc_pkg::REG_IDX_W-1:0] i_waddr,
    input  wire logic [31:0]                    i_wdata,
    input  wire logic [cmmc_pkg::REG_IDX_W-1:0] i_raddr_a,
    input  wire logic [cmmc_pkg::REG_IDX_W-1:0] i_raddr_b,
    output logic [31:0]                         o_rdata_a,
    output logic [31:0]                         o_rdata_b
);
    import cmmc_pkg::*;

    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [31:0]         r_a, r_b;
    logic                r_va, r_vb;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Valid bits: unwritten registers read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        r_a  <= r_mem[i_raddr_a];
        r_b  <= r_mem[i_raddr_b];
        r_va <= r_vld[i_raddr_a];
        r_vb <= r_vld[i_raddr_b];
    end

    assign o_rdata_a = r_va ? r_a : 32'd0;
    assign o_rdata_b = r_vb ? r_b : 32'd0;
endmodule
`default_nettype wire

>>> sv/cmmc_chk.sv
// Port-level checker for the mini MIPS core, bound to the top level.
`default_nettype none
module cmmc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_phase,
    input wire logic        o_reg_write_en,
    input wire logic [2:0]  o_reg_write_index,
    input wire logic [31:0] o_reg_write_value,
    input wire logic        o_mem_write_en
);
    import cmmc_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped under stall");

    // Block a second request while one is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("request taken while busy");

    // Zero the unused register write fields
    a_rzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reg_write_en |-> o_reg_write_index == 3'd0 && o_reg_write_value == 32'd0)
        else $error("stale register write fields");

    // Never write register and memory in one step
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_reg_write_en && o_mem_write_en)) else $error("double write");

    // A store completes an instruction
    a_swph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mem_write_en |-> o_phase == PH_FETCH) else $error("store phase");
endmodule

bind multicycle_mini_mips_core_unit cmmc_chk u_cmmc_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_phase           (o_phase),
    .o_reg_write_en    (o_reg_write_en),
    .o_reg_write_index (o_reg_write_index),
    .o_reg_write_value (o_reg_write_value),
    .o_mem_write_en    (o_mem_write_en)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the multicycle mini MIPS core unit.
`default_nettype none
module testbench;
    import cmmc_pkg::*;

    localparam int MEMD = 256;
    localparam int WDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [7:0]  i_load_addr;
    logic [15:0] i_load_word;
    logic        i_cfg_we;
    logic [8:0]  i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [8:0]  o_pc_value;
    logic [2:0]  o_phase;
    logic        o_halted;
    logic        o_reg_write_en;
    logic [2:0]  o_reg_write_index;
    logic signed [31:0] o_reg_write_value;
    logic        o_mem_write_en;
    logic [7:0]  o_mem_write_addr;
    logic [15:0] o_mem_write_data;
    logic [31:0] o_micro_steps_done;

    typedef struct packed {
        logic [8:0]  pc;
        logic [2:0]  ph;
        logic        hlt;
        logic        rwe;
        logic [2:0]  ridx;
        logic [31:0] rval;
        logic        mwe;
        logic [7:0]  maddr;
        logic [15:0] mdata;
        logic [31:0] steps;
    } t_core_view;

    multicycle_mini_mips_core_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_load_addr(i_load_addr), .i_load_word(i_load_word),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .o_valid(o_valid),
        .i_stall(i_stall), .o_pc_value(o_pc_value), .o_phase(o_phase),
        .o_halted(o_halted), .o_reg_write_en(o_reg_write_en),
        .o_reg_write_index(o_reg_write_index), .o_reg_write_value(o_reg_write_value),
        .o_mem_write_en(o_mem_write_en), .o_mem_write_addr(o_mem_write_addr),
        .o_mem_write_data(o_mem_write_data), .o_micro_steps_done(o_micro_steps_done)
    );

    // Core shadow state
    logic [8:0]  prog_len;
    logic [15:0] mem_words [MEMD];
    logic [31:0] regs [NUM_REGS];
    logic [8:0]  pc;
    logic [15:0] ir;
    logic [31:0] opa, opb, alu_out, mdr, step_cnt;
    logic [2:0]  cur_phase;
    logic        is_halted;

    t_core_view  expected_views[$];
    int          err_cnt;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    int          results_seen;
    int          instrs_run;

    // Clock
    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // Advance the shadow core by one request
    function automatic t_core_view predict_request(logic [1:0] rq, logic [7:0] la,
                                                   logic [15:0] lw);
        t_core_view v;
        logic [3:0] op;
        v = '0;
        op = ir[15:12];
        if (rq == REQ_LOAD) begin
            mem_words[la] = lw;
        end else if (rq == REQ_START) begin
            if (prog_len != 0) is_halted = 1'b0;
        end else if (rq == REQ_STEP && !is_halted) begin
            case (cur_phase)
                PH_FETCH: begin
                    ir = (pc < MEMD) ? mem_words[pc[7:0]] : 16'd0;
                    pc = pc + 9'd1;
                    cur_phase = PH_DECODE;
                end
                PH_DECODE: begin
                    opa = regs[ir[11:9]];
                    opb = regs[ir[8:6]];
                    cur_phase = PH_ALU;
                end
                PH_ALU: begin
                    if (op == OP_RTYPE) begin
                        case (ir[2:0])
                            FN_ADD: alu_out = opa + opb;
                            FN_SUB: alu_out = opa - opb;
                            FN_AND: alu_out = opa & opb;
                            FN_OR:  alu_out = opa | opb;
                            default: alu_out = '0;
                        endcase
                    end else if (op == OP_ADDI || op == OP_LW || op == OP_SW) begin
                        alu_out = opa + {26'd0, ir[5:0]};
                    end
                    cur_phase = PH_WB;
                end
                PH_WB: begin
                    cur_phase = PH_FETCH;
                    instrs_run++;
                    if (op == OP_RTYPE || op == OP_ADDI) begin
                        v.ridx = (op == OP_RTYPE) ? ir[5:3] : ir[8:6];
                        regs[v.ridx] = alu_out;
                        v.rwe = 1'b1;
                        v.rval = alu_out;
                    end else if (op == OP_LW) begin
                        if (alu_out < MEMD)
                            mdr = {{16{mem_words[alu_out[7:0]][15]}},
                                   mem_words[alu_out[7:0]]};
                        cur_phase = PH_LWB;
                    end else if (op == OP_SW) begin
                        if (alu_out < MEMD) begin
                            mem_words[alu_out[7:0]] = opb[15:0];
                            v.mwe = 1'b1;
                            v.maddr = alu_out[7:0];
                            v.mdata = opb[15:0];
                        end
                    end
                end
                PH_LWB: begin
                    if (op == OP_LW) begin
                        v.ridx = ir[8:6];
                        regs[v.ridx] = mdr;
                        v.rwe = 1'b1;
                        v.rval = mdr;
                    end
                    cur_phase = PH_FETCH;
                end
                default: cur_phase = PH_FETCH;
            endcase
            step_cnt = step_cnt + 32'd1;
            if (cur_phase == PH_FETCH && pc >= prog_len) is_halted = 1'b1;
        end
        v.pc = pc;
        v.ph = cur_phase;
        v.hlt = is_halted;
        v.steps = step_cnt;
        return v;
    endfunction

    // Send one request and record its expected result; valid stays high after
    // acceptance until the next request, an idle gap or a drain drops it
    task automatic send_request(logic [1:0] rq, logic [7:0] la, logic [15:0] lw);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= rq;
        i_load_addr <= la;
        i_load_word <= lw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_views.push_back(predict_request(rq, la, lw));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(logic [8:0] len);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        prog_len = len;
    endtask

    function automatic logic [15:0] rand_instr();
        logic [3:0] op;
        case ($urandom_range(9))
            0, 1, 2: op = OP_RTYPE;
            3, 4: op = OP_ADDI;
            5, 6: op = OP_LW;
            7, 8: op = OP_SW;
            default: op = 4'($urandom);
        endcase
        return {op, 12'($urandom)};
    endfunction

    // Load a program at 0, start it and step until it halts or 200 requests are sent
    task automatic run_program(int len, logic full_rand);
        int guard;
        for (int k = 0; k < len; k++)
            send_request(REQ_LOAD, 8'(k), full_rand ? 16'($urandom) : rand_instr());
        write_length(9'(len));
        send_request(REQ_START, 8'($urandom), 16'($urandom));
        guard = 0;
        while (!is_halted && guard < 200) begin
            send_request(($urandom_range(19) == 0) ? 2'($urandom) : REQ_STEP,
                         8'($urandom), 16'($urandom));
            guard++;
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_core_view e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_views.size() == 0) begin
                $error("result with no request outstanding");
                err_cnt++;
            end else begin
                e = expected_views.pop_front();
                if (o_pc_value !== e.pc) begin
                    $error("pc_value exp %0d got %0d", e.pc, o_pc_value); err_cnt++;
                end
                if (o_phase !== e.ph) begin
                    $error("phase exp %0d got %0d", e.ph, o_phase); err_cnt++;
                end
                if (o_halted !== e.hlt) begin
                    $error("halted exp %0d got %0d", e.hlt, o_halted); err_cnt++;
                end
                if (o_reg_write_en !== e.rwe) begin
                    $error("reg_write_en exp %0d got %0d", e.rwe, o_reg_write_en);
                    err_cnt++;
                end
                if (o_reg_write_index !== e.ridx) begin
                    $error("reg_write_index exp %0d got %0d", e.ridx, o_reg_write_index);
                    err_cnt++;
                end
                if (o_reg_write_value !== e.rval) begin
                    $error("reg_write_value exp %0h got %0h", e.rval, o_reg_write_value);
                    err_cnt++;
                end
                if (o_mem_write_en !== e.mwe) begin
                    $error("mem_write_en exp %0d got %0d", e.mwe, o_mem_write_en);
                    err_cnt++;
                end
                if (o_mem_write_addr !== e.maddr) begin
                    $error("mem_write_addr exp %0d got %0d", e.maddr, o_mem_write_addr);
                    err_cnt++;
                end
                if (o_mem_write_data !== e.mdata) begin
                    $error("mem_write_data exp %0h got %0h", e.mdata, o_mem_write_data);
                    err_cnt++;
                end
                if (o_micro_steps_done !== e.steps) begin
                    $error("micro_steps_done exp %0d got %0d", e.steps, o_micro_steps_done);
                    err_cnt++;
                end
            end
        end
    end

    // Randomize receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        // extremes of load fields, halted advance, start with zero length
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_START, 8'hFF, 16'hFFFF);
        send_request(2'd3, 8'hAA, 16'h5555);
        send_request(REQ_LOAD, 8'hFF, 16'hFFFF);
        send_request(REQ_LOAD, 8'h3F, 16'h8001);
        // addi r1 = 63; addi r2 = r1+5; sub r3 = r0-r1; and, or, add, funct 7
        send_request(REQ_LOAD, 8'd0, {OP_ADDI, 3'd0, 3'd1, 6'd63});
        send_request(REQ_LOAD, 8'd1, {OP_ADDI, 3'd1, 3'd2, 6'd5});
        send_request(REQ_LOAD, 8'd2, {OP_RTYPE, 3'd0, 3'd1, 3'd3, FN_SUB});
        send_request(REQ_LOAD, 8'd3, {OP_RTYPE, 3'd1, 3'd2, 3'd4, FN_AND});
        send_request(REQ_LOAD, 8'd4, {OP_RTYPE, 3'd1, 3'd2, 3'd5, FN_OR});
        send_request(REQ_LOAD, 8'd5, {OP_RTYPE, 3'd1, 3'd2, 3'd6, FN_ADD});
        send_request(REQ_LOAD, 8'd6, {OP_RTYPE, 3'd1, 3'd2, 3'd7, 3'd7});
        // lw sign-extended from 63, sw r3 to 62, lw and sw out of range via r3, j opcode
        send_request(REQ_LOAD, 8'd7, {OP_LW, 3'd0, 3'd5, 6'd63});
        send_request(REQ_LOAD, 8'd8, {OP_SW, 3'd0, 3'd3, 6'd62});
        send_request(REQ_LOAD, 8'd9, {OP_LW, 3'd3, 3'd6, 6'd0});
        send_request(REQ_LOAD, 8'd10, {OP_SW, 3'd3, 3'd6, 6'd0});
        send_request(REQ_LOAD, 8'd11, {4'd2, 12'hFFF});
        write_length(9'd12);
        send_request(REQ_START, 8'd0, 16'd0);
        while (!is_halted) send_request(REQ_STEP, 8'($urandom), 16'($urandom));
    endtask

    // Full program length: restart with length 256 and step on from the current PC
    task automatic test_full_length();
        write_length(9'd256);
        send_request(REQ_START, 8'd0, 16'd0);
        for (int k = 0; k < 40 && !is_halted; k++)
            send_request(REQ_STEP, 8'd0, 16'd0);
    endtask

    task automatic test_random_programs();
        int phase_sel;
        phase_sel = 0;
        while (results_seen < 950) begin
            case (phase_sel % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            run_program($urandom_range(1, 8), $urandom_range(9) == 0);
            phase_sel++;
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = REQ_LOAD;
        i_load_addr = '0;
        i_load_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_stall = 1'b0;
        err_cnt = 0;
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        results_seen = 0;
        instrs_run = 0;
        prog_len = '0;
        foreach (mem_words[k]) mem_words[k] = '0;
        foreach (regs[k]) regs[k] = '0;
        pc = '0; ir = '0; opa = '0; opb = '0; alu_out = '0; mdr = '0;
        step_cnt = '0; cur_phase = PH_FETCH; is_halted = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_programs();
        test_full_length();
        write_length(9'd0);
        send_request(REQ_START, 8'd0, 16'd0);

        wait_drained();
        $display("Covered %0d results, %0d instructions retired, lengths 0..256,",
                 results_seen, instrs_run);
        $display("with sender gaps and receiver stalls in four mixes.");
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
